// ===== rtl/msat_pkg.sv =====
// shared types and constants for the session aging table
package msat_pkg;

    localparam int unsigned TableEntries = 256;
    localparam int unsigned IdxW = $clog2(TableEntries);
    localparam int unsigned PtrW = IdxW + 1;
    localparam logic [PtrW-1:0] NilPtr = PtrW'(TableEntries);
    localparam logic [31:0] DefaultLifetime = 32'(3600 * 7 * 100);

    localparam logic [2:0] CmdUpdIp = 3'd0;
    localparam logic [2:0] CmdUpdSess = 3'd1;
    localparam logic [2:0] CmdLkIp = 3'd2;
    localparam logic [2:0] CmdLkSess = 3'd3;
    localparam logic [2:0] CmdFlush = 3'd4;

    localparam logic [1:0] StHit = 2'd0;
    localparam logic [1:0] StMiss = 2'd1;
    localparam logic [1:0] StFull = 2'd2;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [47:0] mac;
        logic [31:0] ip;
        logic [15:0] session_id;
        logic [31:0] now;
    } t_cmd;

    typedef struct packed {
        logic [1:0]  status;
        logic [47:0] out_mac;
        logic [31:0] out_ip;
        logic [15:0] out_session;
    } t_rsp;

    // one entry of the table memory
    typedef struct packed {
        logic [47:0]     mac;
        logic [31:0]     ip;
        logic [15:0]     session;
        logic [31:0]     expiry;
        logic [PtrW-1:0] next;
    } t_entry;

    localparam int unsigned EntryW = $bits(t_entry);

endpackage

// ===== rtl/msat_ram.sv =====
// single port entry memory with registered read
module msat_ram #(
    parameter int unsigned Depth = 256,
    parameter int unsigned Width = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_addr,
    input  logic [Width-1:0]         i_wdata,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

// ===== rtl/mac_ip_session_aging_table_unit.sv =====
// top level of the mac / ip / session aging table
//
//  channel | signals                     | dir | transfer
//  cmd     | i_cmd, start, busy          | in  | start && !busy
//  result  | o_rsp, o_rsp_valid          | out | o_rsp_valid (one cycle)
//  config  | i_cfg_data, cfg_valid/ready | in  | cfg_valid && cfg_ready
//
// step sequence from the accepting edge: flush and unknown codes go straight
// to SDone; a walk visits at most 256 entries, each list step being a read of
// the single port entry memory (SRead) and a compare (SEval); a miss ends in
// SDone, or in SWrite then SDone with an insert; a hit goes through SWrite
// to SDone, a lookup ip hit straight to SDone; each unlink behind a kept
// entry adds a link write (SLink); unlinks and writebacks share that port
// busy drops in the cycle that carries the result strobe, so the next
// command can be taken at the edge that takes the result
// free slots are found by a priority search over the valid bit vector
// reset empties the table at once through the valid bits; no clearing pass
// results cannot be stalled; the strobe lasts exactly one cycle
module mac_ip_session_aging_table_unit
    import msat_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  start,
    output logic  busy,
    input  t_cmd  i_cmd,
    output logic  o_rsp_valid,
    output t_rsp  o_rsp,
    input  logic  cfg_valid,
    output logic  cfg_ready,
    input  logic [31:0] i_cfg_data
);
    localparam logic [2:0] SIdle = 3'd0;
    localparam logic [2:0] SRead = 3'd1;
    localparam logic [2:0] SEval = 3'd2;
    localparam logic [2:0] SLink = 3'd3;
    localparam logic [2:0] SWrite = 3'd4;
    localparam logic [2:0] SDone = 3'd5;

    logic [2:0]            r_state;
    t_cmd                  r_cmd;
    logic [31:0]           r_life;
    logic [TableEntries-1:0] r_valid;
    logic [PtrW-1:0]       r_head, r_cur, r_prev;
    logic [PtrW:0]         r_steps;
    t_entry                r_prev_ent;   // copy of prev entry for unlink
    t_entry                r_hit_ent;
    logic [IdxW-1:0]       r_hit_idx;
    logic [1:0]            r_status;
    logic                  r_have;

    // memory port
    logic                  ram_we;
    logic [IdxW-1:0]       ram_addr;
    t_entry                ram_wdata, ram_rdata;

    msat_ram #(.Depth(TableEntries), .Width(EntryW)) u_ram (
        .i_clk(i_clk), .i_we(ram_we), .i_addr(ram_addr),
        .i_wdata(ram_wdata), .o_rdata(ram_rdata)
    );

    assign busy = (r_state != SIdle);
    assign cfg_ready = !busy;

    // lowest free slot
    logic [PtrW-1:0] free_idx;
    always_comb begin
        free_idx = NilPtr;
        for (int i = TableEntries - 1; i >= 0; i--) begin
            if (!r_valid[i]) free_idx = PtrW'(i);
        end
    end

    logic hit, expired, is_upd;
    logic [31:0] new_exp;
    assign is_upd = (r_cmd.cmd == CmdUpdIp) || (r_cmd.cmd == CmdUpdSess);
    assign new_exp = r_cmd.now + r_life;
    always_comb begin
        unique case (r_cmd.cmd)
            CmdUpdIp, CmdUpdSess: hit = (ram_rdata.mac == r_cmd.mac);
            CmdLkIp:  hit = (ram_rdata.ip == r_cmd.ip);
            default:  hit = (r_cmd.session_id != 16'd0)
                            && (ram_rdata.session == r_cmd.session_id);
        endcase
    end
    assign expired = ram_rdata.expiry < r_cmd.now;

    // write-back entry for hit or insert
    t_entry upd_ent;
    always_comb begin
        upd_ent = r_hit_ent;
        if (is_upd) begin
            upd_ent.mac = r_cmd.mac;
            if (r_cmd.cmd == CmdUpdIp) upd_ent.ip = r_cmd.ip;
            else upd_ent.session = r_cmd.session_id;
        end
        upd_ent.expiry = new_exp;
    end

    always_comb begin
        ram_we = 1'b0;
        ram_addr = r_cur[IdxW-1:0];
        ram_wdata = r_prev_ent;
        unique case (r_state)
            SLink: begin
                ram_we = 1'b1;
                ram_addr = r_prev[IdxW-1:0];
            end
            SWrite: begin
                ram_we = 1'b1;
                ram_addr = r_hit_idx;
                ram_wdata = upd_ent;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SIdle;
            r_life <= DefaultLifetime;
            r_valid <= '0;
            r_head <= NilPtr;
            o_rsp_valid <= 1'b0;
        end else begin
            o_rsp_valid <= (r_state == SDone);
            if (cfg_valid && cfg_ready) r_life <= i_cfg_data;
            unique case (r_state)
                SIdle: if (start) begin
                    r_cmd <= i_cmd;
                    r_cur <= r_head;
                    r_prev <= NilPtr;
                    r_steps <= '0;
                    r_have <= 1'b0;
                    if (i_cmd.cmd == CmdFlush) begin
                        r_valid <= '0;
                        r_head <= NilPtr;
                        r_status <= StHit;
                        r_state <= SDone;
                    end else begin
                        r_status <= StMiss;
                        r_state <= (i_cmd.cmd > CmdFlush) ? SDone : SRead;
                    end
                end
                SRead: begin
                    // memory read of r_cur is in flight
                    if (r_cur == NilPtr || r_steps == (PtrW+1)'(TableEntries)) begin
                        if (is_upd && free_idx != NilPtr) begin
                            r_hit_idx <= free_idx[IdxW-1:0];
                            r_hit_ent <= '{mac: '0, ip: '0, session: '0,
                                           expiry: '0, next: r_head};
                            r_valid[free_idx[IdxW-1:0]] <= 1'b1;
                            r_head <= free_idx;
                            r_status <= StHit;
                            r_have <= 1'b1;
                            r_state <= SWrite;
                        end else begin
                            if (is_upd) r_status <= StFull;
                            r_state <= SDone;
                        end
                    end else begin
                        r_state <= SEval;
                    end
                end
                SEval: begin
                    r_steps <= r_steps + 1'b1;
                    if (hit) begin
                        r_hit_idx <= r_cur[IdxW-1:0];
                        r_hit_ent <= ram_rdata;
                        r_have <= 1'b1;
                        r_status <= StHit;
                        r_state <= (r_cmd.cmd == CmdLkIp) ? SDone : SWrite;
                    end else if (expired) begin
                        r_valid[r_cur[IdxW-1:0]] <= 1'b0;
                        r_cur <= ram_rdata.next;
                        r_prev_ent.next <= ram_rdata.next;
                        if (r_prev == NilPtr) begin
                            r_head <= ram_rdata.next;
                            r_state <= SRead;
                        end else begin
                            r_state <= SLink;
                        end
                    end else begin
                        r_prev <= r_cur;
                        r_prev_ent <= ram_rdata;
                        r_cur <= ram_rdata.next;
                        r_state <= SRead;
                    end
                end
                SLink: r_state <= SRead;
                SWrite: begin
                    r_hit_ent <= upd_ent;
                    r_state <= SDone;
                end
                SDone: begin
                    o_rsp.status <= r_status;
                    o_rsp.out_mac <= r_have ? r_hit_ent.mac : 48'd0;
                    o_rsp.out_ip <= r_have ? r_hit_ent.ip : 32'd0;
                    o_rsp.out_session <= r_have ? r_hit_ent.session : 16'd0;
                    r_state <= SIdle;
                end
                default: r_state <= SIdle;
            endcase
        end
    end

    // result strobe only closes a busy command
    a_rsp_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> $past(r_state == SDone)) else $error("stray result");
    // table full only when no slot is free
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == SDone && r_status == StFull) |-> (&r_valid))
        else $error("full with free slot");
    // a started command is taken: busy is high in the cycle after the start
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("start not taken");
endmodule
